// ----- rtl/htsl_pkg.sv -----
// -----------------------------------------------------------------------------
// Hierarchical tile sample lookup - shared definitions
// Field widths, request and response layouts, action codes and the control
// group that travels with each request down the pipeline.
// -----------------------------------------------------------------------------
package htsl_pkg;

   // Defaults for the top-level parameters
   localparam int SCALE_LOG2_DEF = 2;
   localparam int TILE_BITS_DEF  = 8;

   // Fixed field widths
   localparam int INDEX_BITS   = 16;
   localparam int FRAC_BITS    = 24;
   localparam int TILE_FIELD_W = 8;
   localparam int SLOT_FIELD_W = 4;

   // Action codes of a request
   typedef enum logic [1:0] {
      ACT_LINK   = 2'd0,   // write child and order entry
      ACT_POINT  = 2'd1,   // write tile base point
      ACT_SAMPLE = 2'd2    // sample lookup
   } htsl_action_type;

   typedef struct packed {
      logic [1:0]              action;
      logic [TILE_FIELD_W-1:0] tile;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TILE_FIELD_W-1:0] child_tile;
      logic [SLOT_FIELD_W-1:0] visit_slot;
      logic [FRAC_BITS-1:0]    point_x;
      logic [FRAC_BITS-1:0]    point_y;
      logic [INDEX_BITS-1:0]   sample_index;
   } htsl_req_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0]    sample_x;
      logic [FRAC_BITS-1:0]    sample_y;
      logic [TILE_FIELD_W-1:0] final_tile;
   } htsl_rsp_type;

   // Control group carried with every pipeline slot
   typedef struct packed {
      logic            valid;
      htsl_action_type op;
   } htsl_ctrl_type;

endpackage

// ----- rtl/htsl_ram.sv -----
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered and held while the
// read enable is low.
// -----------------------------------------------------------------------------
module htsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/htsl_level.sv -----
// -----------------------------------------------------------------------------
// Hierarchical tile sample lookup - one descent level
// Stage A reads this level's copy of the order table, stage B its copy of the
// child table. Link writes update both copies as they pass, so every copy sees
// writes and lookups in request order.
// -----------------------------------------------------------------------------
module htsl_level #(
   parameter int SCALE_LOG2 = htsl_pkg::SCALE_LOG2_DEF,
   parameter int TILE_BITS  = htsl_pkg::TILE_BITS_DEF,
   parameter int LEVELS     = 4,
   parameter int LEVEL      = 0,
   localparam int DIGIT_BITS = 2 * SCALE_LOG2,
   localparam int ADDR_W     = TILE_BITS + DIGIT_BITS,
   localparam int DEPTH_W    = $clog2(LEVELS + 1),
   localparam int ACC_W      = SCALE_LOG2 * LEVELS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  htsl_pkg::htsl_ctrl_type      in_ctrl,
   input  htsl_pkg::htsl_req_type       in_req,
   input  logic [TILE_BITS-1:0]         in_tile,
   input  logic [htsl_pkg::INDEX_BITS-1:0] in_idx,
   input  logic [DEPTH_W-1:0]           in_depth,
   input  logic [ACC_W-1:0]             in_col,
   input  logic [ACC_W-1:0]             in_row,
   output htsl_pkg::htsl_ctrl_type      out_ctrl,
   output htsl_pkg::htsl_req_type       out_req,
   output logic [TILE_BITS-1:0]         out_tile,
   output logic [htsl_pkg::INDEX_BITS-1:0] out_idx,
   output logic [DEPTH_W-1:0]           out_depth,
   output logic [ACC_W-1:0]             out_col,
   output logic [ACC_W-1:0]             out_row
);
   import htsl_pkg::*;

   // Field position of this level within the offset accumulators
   localparam int FIELD_SHIFT = ACC_W - SCALE_LOG2 * (LEVEL + 1);

   // stage A
   htsl_ctrl_type         a_ctrl_ff;
   logic                  a_step_ff;
   logic                  a_step_in;
   htsl_req_type          a_req_ff;
   logic [TILE_BITS-1:0]  a_tile_ff;
   logic [INDEX_BITS-1:0] a_idx_ff;
   logic [DEPTH_W-1:0]    a_depth_ff;
   logic [ACC_W-1:0]      a_col_ff;
   logic [ACC_W-1:0]      a_row_ff;

   // stage B
   htsl_ctrl_type         b_ctrl_ff;
   logic                  b_step_ff;
   htsl_req_type          b_req_ff;
   logic [TILE_BITS-1:0]  b_tile_ff;
   logic [INDEX_BITS-1:0] b_idx_ff;
   logic [INDEX_BITS-1:0] b_idx_in;
   logic [DEPTH_W-1:0]    b_depth_ff;
   logic [DEPTH_W-1:0]    b_depth_in;
   logic [ACC_W-1:0]      b_col_ff;
   logic [ACC_W-1:0]      b_col_in;
   logic [ACC_W-1:0]      b_row_ff;
   logic [ACC_W-1:0]      b_row_in;

   logic [DIGIT_BITS-1:0] order_rd;
   logic [TILE_BITS-1:0]  child_rd;
   logic                  order_wr_en;
   logic                  child_wr_en;
   logic [ADDR_W-1:0]     order_wr_addr;
   logic [ADDR_W-1:0]     child_wr_addr;

   // A level is taken while a sample request still has index digits left
   assign a_step_in = in_ctrl.valid && (in_ctrl.op == ACT_SAMPLE) && (in_idx != '0);

   // Order table copy: looked up with the low index digit
   assign order_wr_en   = adv && in_ctrl.valid && (in_ctrl.op == ACT_LINK);
   assign order_wr_addr = {TILE_BITS'(in_req.tile), DIGIT_BITS'(in_req.slot)};

   htsl_ram #(
      .WIDTH (DIGIT_BITS),
      .DEPTH (2 ** ADDR_W)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (order_wr_en),
      .wr_addr (order_wr_addr),
      .wr_data (DIGIT_BITS'(in_req.visit_slot)),
      .rd_en   (adv),
      .rd_addr ({in_tile, in_idx[DIGIT_BITS-1:0]}),
      .rd_data (order_rd)
   );

   // Child table copy: looked up with the subtile from the order table
   assign child_wr_en   = adv && a_ctrl_ff.valid && (a_ctrl_ff.op == ACT_LINK);
   assign child_wr_addr = {TILE_BITS'(a_req_ff.tile), DIGIT_BITS'(a_req_ff.slot)};

   htsl_ram #(
      .WIDTH (TILE_BITS),
      .DEPTH (2 ** ADDR_W)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (TILE_BITS'(a_req_ff.child_tile)),
      .rd_en   (adv),
      .rd_addr ({a_tile_ff, order_rd}),
      .rd_data (child_rd)
   );

   // Walk state update for stage B
   always_comb begin
      b_idx_in   = a_idx_ff;
      b_depth_in = a_depth_ff;
      b_col_in   = a_col_ff;
      b_row_in   = a_row_ff;
      if (a_step_ff) begin
         b_idx_in   = a_idx_ff >> DIGIT_BITS;
         b_depth_in = a_depth_ff + DEPTH_W'(1);
         b_col_in   = a_col_ff | (ACC_W'(order_rd[SCALE_LOG2-1:0]) << FIELD_SHIFT);
         b_row_in   = a_row_ff | (ACC_W'(order_rd[DIGIT_BITS-1:SCALE_LOG2]) << FIELD_SHIFT);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctrl_ff <= '0;
         a_step_ff <= 1'b0;
         b_ctrl_ff <= '0;
         b_step_ff <= 1'b0;
      end else if (adv) begin
         a_ctrl_ff <= in_ctrl;
         a_step_ff <= a_step_in;
         b_ctrl_ff <= a_ctrl_ff;
         b_step_ff <= a_step_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         a_req_ff   <= in_req;
         a_tile_ff  <= in_tile;
         a_idx_ff   <= in_idx;
         a_depth_ff <= in_depth;
         a_col_ff   <= in_col;
         a_row_ff   <= in_row;
         b_req_ff   <= a_req_ff;
         b_tile_ff  <= a_tile_ff;
         b_idx_ff   <= b_idx_in;
         b_depth_ff <= b_depth_in;
         b_col_ff   <= b_col_in;
         b_row_ff   <= b_row_in;
      end
   end

   // Move to the child tile when this level was taken
   assign out_ctrl  = b_ctrl_ff;
   assign out_req   = b_req_ff;
   assign out_tile  = b_step_ff ? child_rd : b_tile_ff;
   assign out_idx   = b_idx_ff;
   assign out_depth = b_depth_ff;
   assign out_col   = b_col_ff;
   assign out_row   = b_row_ff;

endmodule

// ----- rtl/htsl_compose.sv -----
// -----------------------------------------------------------------------------
// Hierarchical tile sample lookup - point lookup and composition
// Stage P reads the final tile's base point, stage Q scales it down by the
// depth reached, and the output stage adds in the subtile offsets.
// -----------------------------------------------------------------------------
module htsl_compose #(
   parameter int SCALE_LOG2 = htsl_pkg::SCALE_LOG2_DEF,
   parameter int TILE_BITS  = htsl_pkg::TILE_BITS_DEF,
   parameter int LEVELS     = 4,
   localparam int DEPTH_W    = $clog2(LEVELS + 1),
   localparam int ACC_W      = SCALE_LOG2 * LEVELS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  htsl_pkg::htsl_ctrl_type in_ctrl,
   input  htsl_pkg::htsl_req_type  in_req,
   input  logic [TILE_BITS-1:0]    in_tile,
   input  logic [DEPTH_W-1:0]      in_depth,
   input  logic [ACC_W-1:0]        in_col,
   input  logic [ACC_W-1:0]        in_row,
   output logic                    rsp_valid,
   output htsl_pkg::htsl_rsp_type  rsp_data
);
   import htsl_pkg::*;

   localparam int SUM_W = FRAC_BITS + ACC_W;

   // stage P
   htsl_ctrl_type          p_ctrl_ff;
   logic [TILE_BITS-1:0]   p_tile_ff;
   logic [DEPTH_W-1:0]     p_depth_ff;
   logic [ACC_W-1:0]       p_col_ff;
   logic [ACC_W-1:0]       p_row_ff;

   // stage Q
   htsl_ctrl_type          q_ctrl_ff;
   logic [TILE_BITS-1:0]   q_tile_ff;
   logic [ACC_W-1:0]       q_col_ff;
   logic [ACC_W-1:0]       q_row_ff;
   logic [SUM_W-1:0]       q_shx_ff;
   logic [SUM_W-1:0]       q_shx_in;
   logic [SUM_W-1:0]       q_shy_ff;
   logic [SUM_W-1:0]       q_shy_in;

   // output stage
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   htsl_rsp_type           rsp_data_ff;
   htsl_rsp_type           rsp_data_in;

   logic [2*FRAC_BITS-1:0] point_rd;
   logic                   point_wr_en;
   logic [SUM_W-1:0]       sum_x;
   logic [SUM_W-1:0]       sum_y;

   // Base point table, x in the upper half
   assign point_wr_en = adv && in_ctrl.valid && (in_ctrl.op == ACT_POINT);

   htsl_ram #(
      .WIDTH (2 * FRAC_BITS),
      .DEPTH (2 ** TILE_BITS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (point_wr_en),
      .wr_addr (TILE_BITS'(in_req.tile)),
      .wr_data ({in_req.point_x, in_req.point_y}),
      .rd_en   (adv),
      .rd_addr (in_tile),
      .rd_data (point_rd)
   );

   // Align the point below the levels taken: one subtile step per level
   always_comb begin
      q_shx_in = '0;
      q_shy_in = '0;
      for (int i = 0; i <= LEVELS; i++) begin
         if (p_depth_ff == DEPTH_W'(i)) begin
            q_shx_in = SUM_W'(point_rd[2*FRAC_BITS-1:FRAC_BITS]) << (SCALE_LOG2 * (LEVELS - i));
            q_shy_in = SUM_W'(point_rd[FRAC_BITS-1:0]) << (SCALE_LOG2 * (LEVELS - i));
         end
      end
   end

   // Offsets sit in the top bits; the sum never reaches one
   assign sum_x = {q_col_ff, {FRAC_BITS{1'b0}}} + q_shx_ff;
   assign sum_y = {q_row_ff, {FRAC_BITS{1'b0}}} + q_shy_ff;

   always_comb begin
      rsp_valid_in           = q_ctrl_ff.valid && (q_ctrl_ff.op == ACT_SAMPLE);
      rsp_data_in.sample_x   = sum_x[SUM_W-1 -: FRAC_BITS];
      rsp_data_in.sample_y   = sum_y[SUM_W-1 -: FRAC_BITS];
      rsp_data_in.final_tile = TILE_FIELD_W'(q_tile_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctrl_ff    <= '0;
         q_ctrl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p_ctrl_ff    <= in_ctrl;
         q_ctrl_ff    <= p_ctrl_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         p_tile_ff   <= in_tile;
         p_depth_ff  <= in_depth;
         p_col_ff    <= in_col;
         p_row_ff    <= in_row;
         q_tile_ff   <= p_tile_ff;
         q_col_ff    <= p_col_ff;
         q_row_ff    <= p_row_ff;
         q_shx_ff    <= q_shx_in;
         q_shy_ff    <= q_shy_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/hierarchical_tile_sample_lookup.sv -----
// -----------------------------------------------------------------------------
// Hierarchical tile sample lookup - top level
// A request passes stages A and B of each level, then P, Q and the output stage;
//   LEVELS = ceil(INDEX_BITS / (2*SCALE_LOG2)), two table reads per level.
// Throughput: one request per cycle; a stalled response freezes the pipeline.
// Each level holds its own copy of the child and order tables.
// Reset clears the pipeline valid bits only; table contents are undefined.
// -----------------------------------------------------------------------------
module hierarchical_tile_sample_lookup #(
   parameter int SCALE_LOG2 = htsl_pkg::SCALE_LOG2_DEF,
   parameter int TILE_BITS  = htsl_pkg::TILE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  htsl_pkg::htsl_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output htsl_pkg::htsl_rsp_type rsp_data
);
   import htsl_pkg::*;

   localparam int DIGIT_BITS = 2 * SCALE_LOG2;
   localparam int LEVELS     = (INDEX_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DEPTH_W    = $clog2(LEVELS + 1);
   localparam int ACC_W      = SCALE_LOG2 * LEVELS;

   logic                  adv;
   htsl_ctrl_type         entry_ctrl;

   htsl_ctrl_type         lv_ctrl  [LEVELS+1];
   htsl_req_type          lv_req   [LEVELS+1];
   logic [TILE_BITS-1:0]  lv_tile  [LEVELS+1];
   logic [INDEX_BITS-1:0] lv_idx   [LEVELS+1];
   logic [DEPTH_W-1:0]    lv_depth [LEVELS+1];
   logic [ACC_W-1:0]      lv_col   [LEVELS+1];
   logic [ACC_W-1:0]      lv_row   [LEVELS+1];

   // The whole pipeline moves unless a finished response is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // Decode the action; the unused code enters as a bubble
   always_comb begin
      entry_ctrl.valid = 1'b0;
      entry_ctrl.op    = ACT_LINK;
      case (req_data.action)
         ACT_LINK, ACT_POINT, ACT_SAMPLE: begin
            entry_ctrl.valid = req_valid;
            entry_ctrl.op    = htsl_action_type'(req_data.action);
         end
         default: begin
            entry_ctrl.valid = 1'b0;
         end
      endcase
   end

   assign lv_ctrl[0]  = entry_ctrl;
   assign lv_req[0]   = req_data;
   assign lv_tile[0]  = TILE_BITS'(req_data.tile);
   assign lv_idx[0]   = req_data.sample_index;
   assign lv_depth[0] = '0;
   assign lv_col[0]   = '0;
   assign lv_row[0]   = '0;

   // Descent levels
   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      htsl_level #(
         .SCALE_LOG2 (SCALE_LOG2),
         .TILE_BITS  (TILE_BITS),
         .LEVELS     (LEVELS),
         .LEVEL      (k)
      ) u_level (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_ctrl   (lv_ctrl[k]),
         .in_req    (lv_req[k]),
         .in_tile   (lv_tile[k]),
         .in_idx    (lv_idx[k]),
         .in_depth  (lv_depth[k]),
         .in_col    (lv_col[k]),
         .in_row    (lv_row[k]),
         .out_ctrl  (lv_ctrl[k+1]),
         .out_req   (lv_req[k+1]),
         .out_tile  (lv_tile[k+1]),
         .out_idx   (lv_idx[k+1]),
         .out_depth (lv_depth[k+1]),
         .out_col   (lv_col[k+1]),
         .out_row   (lv_row[k+1])
      );
   end

   // Point lookup and composition
   htsl_compose #(
      .SCALE_LOG2 (SCALE_LOG2),
      .TILE_BITS  (TILE_BITS),
      .LEVELS     (LEVELS)
   ) u_compose (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_ctrl   (lv_ctrl[LEVELS]),
      .in_req    (lv_req[LEVELS]),
      .in_tile   (lv_tile[LEVELS]),
      .in_depth  (lv_depth[LEVELS]),
      .in_col    (lv_col[LEVELS]),
      .in_row    (lv_row[LEVELS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A sample leaving the last level has used up its whole index
   a_index_consumed: assert property (@(posedge clock) disable iff (reset)
      lv_ctrl[LEVELS].valid && (lv_ctrl[LEVELS].op == ACT_SAMPLE) |-> lv_idx[LEVELS] == '0)
      else $error("sample left descent with index digits remaining");

   // A held response freezes the first level
   a_freeze_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(lv_ctrl[1]))
      else $error("pipeline moved while the response was held");

   // A sample leaving descent reaches the output through stages P, Q and the output register
   a_sample_delivered: assert property (@(posedge clock) disable iff (reset)
      (adv && lv_ctrl[LEVELS].valid && (lv_ctrl[LEVELS].op == ACT_SAMPLE))
         ##1 adv ##1 adv |=> rsp_valid)
      else $error("sample request lost between descent and output");
`endif

endmodule
